/* rtl/tvap_pkg.sv */
`timescale 1ns / 1ps
package tvap_pkg;

  // Width of the frame byte counter; lengths are masked to it.
  localparam int LEN_W = 32;

  localparam int HEADER_BYTES = 'h10;
  localparam int WORD_BYTES   = 'h8;
  localparam int BLOB_WORD_BYTES = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int KIND_W   = 4;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 3;
  localparam int FLEN_W   = 32;

  // Request opcodes on the input channel.
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Fixed element type words.
  localparam logic [31:0] TYPE_STRING = 32'd1;
  localparam logic [31:0] TYPE_BUFFER = 32'd2;
  localparam logic [31:0] TYPE_I32    = 32'd3;
  localparam logic [31:0] TYPE_F32    = 32'd5;
  localparam logic [31:0] TYPE_F64    = 32'd6;

  // Type codes held by the configuration registers out of reset.
  localparam logic [CFG_DATA_W-1:0] INTEGER_CODE_RESET = 32'd9;
  localparam logic [CFG_DATA_W-1:0] EMPTY_CODE_RESET   = 32'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTEGER_CODE = 1'b0,
    CFG_EMPTY_CODE   = 1'b1
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_STRING_HDR = 4'd0,
    KIND_BUFFER_HDR = 4'd1,
    KIND_PAYLOAD    = 4'd2,
    KIND_I32        = 4'd3,
    KIND_I64        = 4'd4,
    KIND_F32        = 4'd5,
    KIND_F64        = 4'd6,
    KIND_U64        = 4'd7,
    KIND_END        = 4'd8,
    KIND_ERROR      = 4'd9
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_TRUNC    = 3'd4
  } status_e;

  // Type codes held by the configuration registers.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] integer_code;
    logic [CFG_DATA_W-1:0] empty_code;
  } cfg_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic             is_start;
    logic             short_len;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] length;
  } q_item_t;

endpackage

/* rtl/tvap_if.sv */
`timescale 1ns / 1ps
interface tvap_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [7:0]                 data_byte;
  logic [tvap_pkg::FLEN_W-1:0] frame_length;
  modport source (output valid, output op, output data_byte, output frame_length,
                  input ready);
  modport sink (input valid, input op, input data_byte, input frame_length,
                output ready);
endinterface

interface tvap_out_if;
  logic                          valid;
  logic                          ready;
  logic [tvap_pkg::KIND_W-1:0]   kind;
  logic [tvap_pkg::VALUE_W-1:0]  value;
  logic [tvap_pkg::STATUS_W-1:0] status;
  logic                          frame_end;
  modport source (output valid, output kind, output value, output status,
                  output frame_end, input ready);
  modport sink (input valid, input kind, input value, input status,
                input frame_end, output ready);
endinterface

interface tvap_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tvap_pkg::CFG_IDX_W-1:0]  index;
  logic [tvap_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/tvap_front.sv */
`timescale 1ns / 1ps
module tvap_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tvap_in_if.sink           in_i,
  output logic              q_valid_o,
  output tvap_pkg::q_item_t q_item_o,
  input  logic              q_pop_i
);
  import tvap_pkg::*;

  q_item_t            mem_q [QUEUE_DEPTH];
  q_item_t            item;
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]    cnt_q, cnt_d;
  logic               push;

  // Classify the request: start or byte, masked length, short frame.
  always_comb begin
    item.is_start  = (in_i.op == OP_START);
    item.data_byte = in_i.data_byte;
    item.length    = LEN_W'(in_i.frame_length);
    item.short_len = (item.length < LEN_W'(HEADER_BYTES));
  end

  assign in_i.ready = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> (cnt_q != '0))
    else $error("queue popped while empty");
`endif

endmodule

/* rtl/tvap_back.sv */
`timescale 1ns / 1ps
module tvap_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tvap_pkg::cfg_t    cfg_i,
  input  logic              q_valid_i,
  input  tvap_pkg::q_item_t q_item_i,
  output logic              q_pop_o,
  tvap_out_if.source        out_o
);
  import tvap_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_CAP, PH_SIZE, PH_TYPE, PH_LEN, PH_VALUE, PH_PAYLOAD
  } phase_e;

  phase_e             ph_q, ph_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [LEN_W-1:0]   left_q, left_d;
  logic [63:0]        ws_q, ws_d;
  logic [2:0]         et_q, et_d;
  logic [31:0]        pl_q, pl_d;
  logic               fail_q, fail_d;

  logic               out_valid_q;
  logic [KIND_W-1:0]  out_kind_q;
  logic [63:0]        out_value_q;
  logic [STATUS_W-1:0] out_status_q;
  logic               out_end_q;

  logic               res_v;
  kind_e              res_kind;
  logic [63:0]        res_val;
  status_e            res_st;
  logic               res_end;

  logic               out_free;
  logic               last;
  logic               tail;
  logic [3:0]         cnt_n;
  logic [63:0]        ws_n;
  logic [31:0]        pl_n;
  logic [31:0]        t_word;
  logic [3:0]         need;

  assign out_free = !out_valid_q || out_o.ready;
  assign q_pop_o  = q_valid_i && out_free;

  // Byte lane insert for the field being collected.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ws_n[8*i +: 8] = (cnt_q[2:0] == 3'(i)) ? q_item_i.data_byte : ws_q[8*i +: 8];
    end
    cnt_n  = cnt_q + 4'd1;
    pl_n   = pl_q - 32'd1;
    t_word = ws_n[31:0];
    need   = ((et_q == 3'(KIND_I32)) || (et_q == 3'(KIND_F32))) ? 4'(BLOB_WORD_BYTES)
                                                                : 4'(WORD_BYTES);
    last   = (left_q == LEN_W'(1));
  end

  always_comb begin
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    left_d   = left_q;
    ws_d     = ws_q;
    et_d     = et_q;
    pl_d     = pl_q;
    fail_d   = fail_q;
    res_v    = 1'b0;
    res_kind = KIND_END;
    res_val  = '0;
    res_st   = ST_OK;
    res_end  = 1'b0;
    tail     = 1'b0;
    if (q_pop_o) begin
      if (q_item_i.is_start) begin
        cnt_d  = '0;
        ws_d   = '0;
        et_d   = '0;
        pl_d   = '0;
        fail_d = 1'b0;
        if (q_item_i.short_len) begin
          ph_d     = PH_IDLE;
          left_d   = '0;
          res_v    = 1'b1;
          res_kind = KIND_ERROR;
          res_st   = ST_SHORT;
          res_end  = 1'b1;
        end else begin
          ph_d   = PH_CAP;
          left_d = q_item_i.length;
        end
      end else if (ph_q != PH_IDLE) begin
        left_d = left_q - LEN_W'(1);
        if (fail_q) begin
          // Swallow the rest of a failed frame.
          if (last) begin
            fail_d = 1'b0;
            ph_d   = PH_IDLE;
          end
        end else if (ph_q == PH_PAYLOAD) begin
          pl_d     = pl_n;
          res_v    = 1'b1;
          res_kind = KIND_PAYLOAD;
          res_val  = 64'(q_item_i.data_byte);
          if (last) begin
            ph_d    = PH_IDLE;
            res_end = 1'b1;
            if (pl_n != '0) begin
              res_kind = KIND_ERROR;
              res_val  = '0;
              res_st   = ST_TRUNC;
            end
          end else if (pl_n == '0) begin
            ph_d = PH_TYPE;
          end
        end else begin
          cnt_d = cnt_n;
          ws_d  = ws_n;
          tail  = 1'b1;
          unique case (ph_q)
            PH_CAP: begin
              if (cnt_n == 4'(WORD_BYTES)) begin
                cnt_d = '0;
                ws_d  = '0;
                ph_d  = PH_SIZE;
              end
            end
            PH_SIZE: begin
              if (cnt_n == 4'(WORD_BYTES)) begin
                cnt_d = '0;
                ws_d  = '0;
                tail  = 1'b0;
                if (ws_n != 64'(left_d)) begin
                  if (last) ph_d = PH_IDLE;
                  else      fail_d = 1'b1;
                  res_v    = 1'b1;
                  res_kind = KIND_ERROR;
                  res_st   = ST_MISMATCH;
                  res_end  = last;
                end else if (last) begin
                  ph_d     = PH_IDLE;
                  res_v    = 1'b1;
                  res_kind = KIND_END;
                  res_end  = 1'b1;
                end else begin
                  ph_d = PH_TYPE;
                end
              end
            end
            PH_TYPE: begin
              if (cnt_n == 4'(BLOB_WORD_BYTES)) begin
                cnt_d = '0;
                ws_d  = '0;
                if ((t_word >= TYPE_STRING) && (t_word <= TYPE_F64)) begin
                  // Strings and buffers map onto header kinds 0 and 1.
                  if (t_word <= TYPE_BUFFER) begin
                    et_d = 3'(t_word - TYPE_STRING);
                    ph_d = PH_LEN;
                  end else begin
                    et_d = 3'(t_word);
                    ph_d = PH_VALUE;
                  end
                end else if (t_word == cfg_i.integer_code) begin
                  et_d = 3'(KIND_U64);
                  ph_d = PH_VALUE;
                end else if (t_word == cfg_i.empty_code) begin
                  tail = 1'b0;
                  if (last) begin
                    ph_d     = PH_IDLE;
                    res_v    = 1'b1;
                    res_kind = KIND_END;
                    res_end  = 1'b1;
                  end
                end else begin
                  tail = 1'b0;
                  if (last) ph_d = PH_IDLE;
                  res_v    = 1'b1;
                  res_kind = KIND_ERROR;
                  res_st   = ST_UNKNOWN;
                  res_end  = last;
                end
              end
            end
            PH_LEN: begin
              if (cnt_n == 4'(BLOB_WORD_BYTES)) begin
                cnt_d = '0;
                ws_d  = '0;
                tail  = 1'b0;
                pl_d  = t_word;
                res_v    = 1'b1;
                res_kind = kind_e'(KIND_W'(et_q));
                if (last) begin
                  ph_d    = PH_IDLE;
                  res_end = 1'b1;
                  if (t_word != '0) begin
                    res_kind = KIND_ERROR;
                    res_st   = ST_TRUNC;
                  end
                end else begin
                  ph_d    = (t_word != '0) ? PH_PAYLOAD : PH_TYPE;
                  res_val = 64'(t_word);
                end
              end
            end
            PH_VALUE: begin
              if (cnt_n == need) begin
                cnt_d    = '0;
                ws_d     = '0;
                tail     = 1'b0;
                ph_d     = last ? PH_IDLE : PH_TYPE;
                res_v    = 1'b1;
                res_kind = kind_e'(KIND_W'(et_q));
                res_val  = ws_n;
                res_end  = last;
              end
            end
            default: begin
              tail = 1'b0;
              ph_d = PH_IDLE;
            end
          endcase
          // Frame ran out in the middle of a field.
          if (tail && last) begin
            ph_d     = PH_IDLE;
            cnt_d    = '0;
            ws_d     = '0;
            res_v    = 1'b1;
            res_kind = KIND_ERROR;
            res_st   = ST_TRUNC;
            res_end  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      cnt_q       <= '0;
      left_q      <= '0;
      ws_q        <= '0;
      et_q        <= '0;
      pl_q        <= '0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      left_q <= left_d;
      ws_q   <= ws_d;
      et_q   <= et_d;
      pl_q   <= pl_d;
      fail_q <= fail_d;
      if (q_pop_o && res_v) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && res_v) begin
      out_kind_q   <= res_kind;
      out_value_q  <= res_val;
      out_status_q <= res_st;
      out_end_q    <= res_end;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.value     = out_value_q;
  assign out_o.status    = out_status_q;
  assign out_o.frame_end = out_end_q;

`ifndef SYNTHESIS
  a_idle_not_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q == PH_IDLE) |-> !fail_q)
    else $error("failed flag left set while idle");
  a_active_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PH_IDLE) |-> (left_q != '0))
    else $error("frame active with no bytes left");
  a_payload_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ph_q == PH_PAYLOAD) && !fail_q) |-> ((pl_q != '0) && (cnt_q == '0)))
    else $error("payload phase with nothing owed");
`endif

endmodule

/* rtl/typed_value_array_parser.sv */
`timescale 1ns / 1ps
// A request accepted into the queue is popped by the parser, which registers any result in the output register.
// Throughput: one request per cycle; the queue pops one request and the parser registers
// at most one result each cycle, limited only by output back-pressure.
// Reset (rst_ni low, asynchronous): parser idle, queue empty, output empty,
// integer type code 9, empty-key type code 10. No clearing pass.
module typed_value_array_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  tvap_in_if.sink    in_i,
  tvap_cfg_if.sink   cfg_i,
  tvap_out_if.source out_o
);
  import tvap_pkg::*;

  // Configuration registers; write only while the parser is quiet (not enforced by the block).
  logic [CFG_DATA_W-1:0] int_code_q;
  logic [CFG_DATA_W-1:0] empty_code_q;
  cfg_t                  cfg;

  q_item_t               q_item;
  logic                  q_valid;
  logic                  q_pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_code_q   <= INTEGER_CODE_RESET;
      empty_code_q <= EMPTY_CODE_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_INTEGER_CODE: int_code_q   <= cfg_i.data;
        CFG_EMPTY_CODE:   empty_code_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.integer_code = int_code_q;
    cfg.empty_code   = empty_code_q;
  end

  // Front: accept and classify requests, hold them in a short queue.
  tvap_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Back: run the frame state machine and drive the output register.
  tvap_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import tvap_pkg::*;

  localparam int SETTING_COUNT     = 6;
  localparam int REQUESTS_PER_PASS = 290;
  // Covers results still held in the output register plus requests still moving through the input queue.
  localparam int DRAIN_CYCLES      = 12;

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_CAPACITY,
    PARSE_SIZE,
    PARSE_TYPE,
    PARSE_BLOB_LEN,
    PARSE_VALUE,
    PARSE_PAYLOAD
  } parse_phase_e;

  typedef struct packed {
    logic              op;
    logic [7:0]        data_byte;
    logic [FLEN_W-1:0] frame_length;
  } frame_request_t;

  typedef struct packed {
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic               frame_end;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_ni;

  tvap_in_if  in_bus ();
  tvap_out_if out_bus ();
  tvap_cfg_if cfg_bus ();

  typed_value_array_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  always #10 clk = ~clk;

  // Request traffic and the results the parser owes for it.
  frame_request_t request_queue[$];
  parse_result_t  expected_results[$];
  logic [7:0]     element_bytes[$];

  int  requests_queued;
  int  requests_accepted;
  int  stimulus_count;
  int  results_checked;
  int  payload_results;
  int  error_results;
  int  error_count;
  int  settings_applied;
  int  sender_idle_pct;
  int  receiver_idle_pct;
  bit  request_taken;

  logic [31:0] integer_settings[SETTING_COUNT];
  logic [31:0] empty_settings[SETTING_COUNT];

  // Mirror of the parser: type code registers and frame walk state.
  logic [31:0]        integer_code;
  logic [31:0]        empty_key_code;
  parse_phase_e       parse_phase;
  int                 field_count;
  logic [LEN_W-1:0]   bytes_left;
  logic [63:0]        field_shift;
  kind_e              element_kind;
  logic [31:0]        blob_left;
  bit                 frame_dropped;

  function automatic void owe_result(kind_e k, logic [63:0] v, status_e s, logic e);
    parse_result_t r;
    r = '{kind: k, value: v, status: s, frame_end: e};
    expected_results.push_back(r);
  endfunction

  function automatic void clear_field();
    field_count = 0;
    field_shift = '0;
  endfunction

  // Advance the mirror by one accepted request and record any result it causes.
  function automatic void predict_request(logic op, logic [7:0] b, logic [FLEN_W-1:0] flen);
    logic        is_last;
    logic [31:0] word;
    logic [63:0] wide;
    int          need;
    if (op == OP_START) begin
      clear_field();
      element_kind  = KIND_STRING_HDR;
      blob_left     = '0;
      frame_dropped = 1'b0;
      if (flen < HEADER_BYTES) begin
        parse_phase = PARSE_IDLE;
        bytes_left  = '0;
        owe_result(KIND_ERROR, '0, ST_SHORT, 1'b1);
        return;
      end
      parse_phase = PARSE_CAPACITY;
      bytes_left  = flen;
      return;
    end

    // Bytes outside a frame are dropped without a result.
    if (parse_phase == PARSE_IDLE) return;

    is_last    = (bytes_left == 1);
    bytes_left = bytes_left - 1'b1;

    // After a size mismatch swallow the rest of the frame.
    if (frame_dropped) begin
      if (is_last) begin
        frame_dropped = 1'b0;
        parse_phase   = PARSE_IDLE;
      end
      return;
    end

    if (parse_phase == PARSE_PAYLOAD) begin
      blob_left = blob_left - 1'b1;
      if (is_last) begin
        parse_phase = PARSE_IDLE;
        if (blob_left != 0) owe_result(KIND_ERROR, '0, ST_TRUNC, 1'b1);
        else owe_result(KIND_PAYLOAD, 64'(b), ST_OK, 1'b1);
        return;
      end
      if (blob_left == 0) parse_phase = PARSE_TYPE;
      owe_result(KIND_PAYLOAD, 64'(b), ST_OK, 1'b0);
      return;
    end

    // Little-endian field assembly.
    field_shift = field_shift | (64'(b) << (8 * field_count));
    field_count = field_count + 1;

    case (parse_phase)
      PARSE_CAPACITY: begin
        if (field_count == WORD_BYTES) begin
          clear_field();
          parse_phase = PARSE_SIZE;
        end
      end
      PARSE_SIZE: begin
        if (field_count == WORD_BYTES) begin
          wide = field_shift;
          clear_field();
          if (wide != 64'(bytes_left)) begin
            if (is_last) parse_phase = PARSE_IDLE;
            else frame_dropped = 1'b1;
            owe_result(KIND_ERROR, '0, ST_MISMATCH, is_last);
            return;
          end
          if (is_last) begin
            parse_phase = PARSE_IDLE;
            owe_result(KIND_END, '0, ST_OK, 1'b1);
            return;
          end
          parse_phase = PARSE_TYPE;
          return;
        end
      end
      PARSE_TYPE: begin
        if (field_count == BLOB_WORD_BYTES) begin
          word = field_shift[31:0];
          clear_field();
          // Fixed codes shadow the unsigned code, which shadows the empty-key code.
          if (word >= TYPE_STRING && word <= TYPE_F64) begin
            if (word <= TYPE_BUFFER) begin
              element_kind = kind_e'(word[3:0] - 4'd1);
              parse_phase  = PARSE_BLOB_LEN;
            end else begin
              element_kind = kind_e'(word[3:0]);
              parse_phase  = PARSE_VALUE;
            end
          end else if (word == integer_code) begin
            element_kind = KIND_U64;
            parse_phase  = PARSE_VALUE;
          end else if (word == empty_key_code) begin
            if (is_last) begin
              parse_phase = PARSE_IDLE;
              owe_result(KIND_END, '0, ST_OK, 1'b1);
            end
            return;
          end else begin
            if (is_last) parse_phase = PARSE_IDLE;
            owe_result(KIND_ERROR, '0, ST_UNKNOWN, is_last);
            return;
          end
        end
      end
      PARSE_BLOB_LEN: begin
        if (field_count == BLOB_WORD_BYTES) begin
          word = field_shift[31:0];
          clear_field();
          blob_left = word;
          if (is_last) begin
            parse_phase = PARSE_IDLE;
            if (word != 0) owe_result(KIND_ERROR, '0, ST_TRUNC, 1'b1);
            else owe_result(element_kind, '0, ST_OK, 1'b1);
            return;
          end
          parse_phase = (word != 0) ? PARSE_PAYLOAD : PARSE_TYPE;
          owe_result(element_kind, 64'(word), ST_OK, 1'b0);
          return;
        end
      end
      PARSE_VALUE: begin
        need = (element_kind == KIND_I32 || element_kind == KIND_F32) ? 4 : 8;
        if (field_count == need) begin
          wide = field_shift;
          clear_field();
          parse_phase = is_last ? PARSE_IDLE : PARSE_TYPE;
          owe_result(element_kind, wide, ST_OK, is_last);
          return;
        end
      end
      default: begin
        parse_phase = PARSE_IDLE;
        return;
      end
    endcase

    // Frame ran out in the middle of a field.
    if (is_last) begin
      parse_phase = PARSE_IDLE;
      clear_field();
      owe_result(KIND_ERROR, '0, ST_TRUNC, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders: queue requests for the driver, no time passes here.
  // ---------------------------------------------------------------------------

  function automatic void queue_request(logic op, logic [7:0] b, logic [31:0] flen,
                                        bit counted);
    frame_request_t r;
    r = '{op: op, data_byte: b, frame_length: flen};
    request_queue.push_back(r);
    requests_queued++;
    if (counted) stimulus_count++;
  endfunction

  function automatic void append_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) element_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic bit is_known_code(logic [31:0] c);
    return (c >= TYPE_STRING && c <= TYPE_F64) || c == integer_code || c == empty_key_code;
  endfunction

  function automatic logic [31:0] pick_unknown_code();
    logic [31:0] c;
    do begin
      c = $urandom_range(1) ? 32'($urandom_range(15)) : 32'($urandom);
    end while (is_known_code(c));
    return c;
  endfunction

  // Append one element, picked so that the parser mostly walks well-formed content.
  function automatic void append_element();
    int          pick;
    int          n;
    logic [31:0] code;
    pick = $urandom_range(15);
    case (pick)
      0, 1, 2, 3: begin
        code = pick[0] ? TYPE_BUFFER : TYPE_STRING;
        // Now and then a huge blob length that eats the rest of the frame.
        if (pick == 3 && $urandom_range(2) == 0) begin
          append_le(64'(code), 4);
          append_le(64'($urandom), 4);
          repeat ($urandom_range(3)) element_bytes.push_back(8'($urandom));
        end else begin
          n = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 6);
          append_le(64'(code), 4);
          append_le(64'(n), 4);
          repeat (n) element_bytes.push_back(8'($urandom));
        end
      end
      4, 5, 6, 7: begin
        code = TYPE_I32 + 32'(pick - 4);
        append_le(64'(code), 4);
        append_le({$urandom, $urandom}, (code == TYPE_I32 || code == TYPE_F32) ? 4 : 8);
      end
      8, 9: begin
        if (integer_code >= TYPE_STRING && integer_code <= TYPE_F64) begin
          append_le(64'(pick_unknown_code()), 4);
        end else begin
          append_le(64'(integer_code), 4);
          append_le({$urandom, $urandom}, 8);
        end
      end
      10, 11: begin
        if ((empty_key_code >= TYPE_STRING && empty_key_code <= TYPE_F64) ||
            empty_key_code == integer_code) begin
          append_le(64'(pick_unknown_code()), 4);
        end else begin
          append_le(64'(empty_key_code), 4);
        end
      end
      default: append_le(64'(pick_unknown_code()), 4);
    endcase
  endfunction

  // Queue one frame: mostly well-formed, with truncated, mismatched,
  // abandoned and overlong variants mixed in.
  function automatic void queue_frame();
    int          body_len;
    int          stream_len;
    int          extra;
    int          mode;
    logic [31:0] flen;
    logic [63:0] capacity;
    logic [63:0] size_word;
    logic [7:0]  b;
    element_bytes.delete();
    repeat ($urandom_range(5)) append_element();
    body_len = element_bytes.size();

    case ($urandom_range(3))
      0:       capacity = '1;
      1:       capacity = '0;
      default: capacity = {$urandom, $urandom};
    endcase

    flen       = 32'(HEADER_BYTES + body_len);
    size_word  = 64'(body_len);
    stream_len = HEADER_BYTES + body_len;
    extra      = 0;
    mode       = $urandom_range(99);
    if (mode < 12 && body_len > 0) begin
      // Declared frame ends inside the element stream.
      stream_len = HEADER_BYTES + $urandom_range(body_len - 1);
      flen       = 32'(stream_len);
      size_word  = 64'(stream_len - HEADER_BYTES);
    end else if (mode < 22) begin
      size_word = size_word ^ (64'd1 << $urandom_range(63));
    end else if (mode < 28) begin
      // Abandon the frame; the next start drops it.
      stream_len = $urandom_range(HEADER_BYTES + body_len - 1);
    end else if (mode < 33) begin
      extra = $urandom_range(1, 3);
    end

    queue_request(OP_START, 8'($urandom), flen, 1'b1);
    for (int i = 0; i < stream_len; i++) begin
      if (i < WORD_BYTES) b = capacity[8*i +: 8];
      else if (i < HEADER_BYTES) b = size_word[8*(i - WORD_BYTES) +: 8];
      else b = element_bytes[i - HEADER_BYTES];
      queue_request(OP_BYTE, b, $urandom, 1'b1);
    end
    // Bytes past the frame end are ignored by the parser.
    repeat (extra) queue_request(OP_BYTE, 8'($urandom), $urandom, 1'b0);
  endfunction

  function automatic void queue_random_unit();
    int sel;
    sel = $urandom_range(99);
    if (sel < 82) begin
      queue_frame();
    end else if (sel < 90) begin
      queue_request(OP_START, 8'($urandom), 32'($urandom_range(15)), 1'b1);
    end else if (sel < 95) begin
      repeat ($urandom_range(1, 3)) queue_request(OP_BYTE, 8'($urandom), $urandom, 1'b0);
    end else begin
      // Wide random length, a few bytes, then cut off by whatever comes next.
      queue_request(OP_START, 8'($urandom), $urandom, 1'b1);
      repeat ($urandom_range(4)) queue_request(OP_BYTE, 8'($urandom), $urandom, 1'b1);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing tasks
  // ---------------------------------------------------------------------------

  // Hold until every request is taken and every result has come back, then
  // let the pipeline settle for requests that cause no result.
  task automatic wait_for_drain();
    while (requests_accepted != requests_queued || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    if (idx == CFG_INTEGER_CODE) integer_code = value;
    else empty_key_code = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued requests at the falling edge, hold until taken.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst_ni && in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
      predict_request(in_bus.op, in_bus.data_byte, in_bus.frame_length);
      requests_accepted++;
      request_taken = 1'b1;
    end
  end

  always @(negedge clk) begin : drive_requests
    frame_request_t r;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || request_taken) begin
      request_taken = 1'b0;
      if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        r = request_queue.pop_front();
        in_bus.valid        <= 1'b1;
        in_bus.op           <= r.op;
        in_bus.data_byte    <= r.data_byte;
        in_bus.frame_length <= r.frame_length;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_bus.ready <= rst_ni && ($urandom_range(99) >= receiver_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each taken result with the oldest owed one.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    parse_result_t want;
    if (rst_ni && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      results_checked++;
      if (out_bus.kind == KIND_PAYLOAD) payload_results++;
      if (out_bus.kind == KIND_ERROR) error_results++;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result kind=%0d value=%h status=%0d frame_end=%0b, expected none",
                 $time, out_bus.kind, out_bus.value, out_bus.status, out_bus.frame_end);
      end else begin
        want = expected_results.pop_front();
        if (out_bus.kind !== want.kind || out_bus.value !== want.value ||
            out_bus.status !== want.status || out_bus.frame_end !== want.frame_end) begin
          error_count++;
          $display("%0t: expected kind=%0d value=%h status=%0d frame_end=%0b",
                   $time, want.kind, want.value, want.status, want.frame_end);
          $display("%0t:   actual kind=%0d value=%h status=%0d frame_end=%0b",
                   $time, out_bus.kind, out_bus.value, out_bus.status, out_bus.frame_end);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int target;
    // Drive every input to a known value before the first edge.
    rst_ni              = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.op           = OP_START;
    in_bus.data_byte    = '0;
    in_bus.frame_length = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = CFG_INTEGER_CODE;
    cfg_bus.data        = '0;
    out_bus.ready       = 1'b0;
    request_taken       = 1'b0;

    integer_code    = INTEGER_CODE_RESET;
    empty_key_code  = EMPTY_CODE_RESET;
    parse_phase     = PARSE_IDLE;
    bytes_left      = '0;
    element_kind    = KIND_STRING_HDR;
    blob_left       = '0;
    frame_dropped   = 1'b0;
    clear_field();

    // Reset values, both extremes each way, shadowed codes, then random codes.
    integer_settings = '{INTEGER_CODE_RESET, 32'd0, 32'hFFFF_FFFF, TYPE_I32,
                         $urandom, $urandom};
    empty_settings   = '{EMPTY_CODE_RESET, 32'hFFFF_FFFF, 32'd0, TYPE_I32,
                         TYPE_F32, $urandom};

    sender_idle_pct   = 23;
    receiver_idle_pct = 45;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed: short lengths, a stray byte, a restart, and a minimal frame
    // whose only type word is all ones and lands on the last byte.
    queue_request(OP_START, 8'h00, 32'd0, 1'b1);
    queue_request(OP_BYTE, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    queue_request(OP_START, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    queue_request(OP_START, 8'h00, 32'd15, 1'b1);
    queue_request(OP_START, 8'h00, 32'd20, 1'b1);
    repeat (WORD_BYTES) queue_request(OP_BYTE, 8'hFF, '0, 1'b1);
    for (int i = 0; i < WORD_BYTES; i++)
      queue_request(OP_BYTE, (i == 0) ? 8'd4 : 8'd0, '0, 1'b1);
    repeat (BLOB_WORD_BYTES) queue_request(OP_BYTE, 8'hFF, '0, 1'b1);
    wait_for_drain();

    // Random passes, one per register setting, stall profile changing every two.
    for (int s = 0; s < SETTING_COUNT; s++) begin
      sender_idle_pct   = (s < 2) ? 23 : (s < 4) ? 45 : 0;
      receiver_idle_pct = (s < 2) ? 45 : (s < 4) ? 23 : 0;
      write_register(CFG_INTEGER_CODE, integer_settings[s]);
      write_register(CFG_EMPTY_CODE, empty_settings[s]);
      settings_applied++;
      target = stimulus_count + REQUESTS_PER_PASS;
      while (stimulus_count < target) queue_random_unit();
      // Close any open frame so the next register write lands on an idle parser.
      queue_request(OP_START, 8'($urandom), 32'($urandom_range(15)), 1'b1);
      wait_for_drain();
    end

    $display("Covered %0d requests over %0d type code settings and three stall profiles.",
             requests_accepted, settings_applied);
    $display("Checked %0d results: %0d payload bytes, %0d error reports.",
             results_checked, payload_results, error_results);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* files.f */
rtl/tvap_pkg.sv
rtl/tvap_if.sv
rtl/tvap_front.sv
rtl/tvap_back.sv
rtl/typed_value_array_parser.sv
verif/testbench.sv
